[hdl/button_debounce_autorepeat_assert.svh]
// Assertion helpers for the asserting file of the debouncer.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bda assertion failed");

// Next-cycle implication, disabled while in reset.
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bda assertion failed");

`endif

[hdl/bda_pkg.sv]
package bda_pkg;

    localparam int CMD_W    = 2;
    localparam int PIN_W    = 6;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST = 8'd5;
    localparam logic [CNT_W-1:0] REPEAT_FIRST_RST   = 8'd50;
    localparam logic [CNT_W-1:0] REPEAT_RELOAD_RST  = 8'd37;
    localparam logic [PIN_W-1:0] REPEAT_MASK_RST    = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPEAT_MASK   = 2'd0,
        REG_DEBOUNCE      = 2'd1,
        REG_REPEAT_FIRST  = 2'd2,
        REG_REPEAT_RELOAD = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_COUNT     = 2'd0,
        PH_PRESSED   = 2'd1,
        PH_PROCESSED = 2'd2,
        PH_STILL     = 2'd3
    } phase_t;

    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STILL   = 2'd2;

    typedef struct packed {
        logic tick;
        logic query_hit;
        logic flush;
        logic pin_high;
        logic rep_en;
    } lane_step_t;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] repeat_first;
        logic [CNT_W-1:0] repeat_reload;
    } lane_cfg_t;

    typedef struct packed {
        logic                pressed;
        logic [STATUS_W-1:0] status;
    } lane_out_t;

endpackage

[hdl/bda_if.sv]
interface bda_in_if;
    logic                          valid;
    logic                          ready;
    logic [bda_pkg::CMD_W-1:0]     command;
    logic [bda_pkg::PIN_W-1:0]     pin_levels;
    logic [bda_pkg::IDX_W-1:0]     button_index;

    modport source (output valid, output command, output pin_levels, output button_index,
                    input ready);
    modport sink   (input valid, input command, input pin_levels, input button_index,
                    output ready);
endinterface

interface bda_out_if;
    logic                          valid;
    logic                          ready;
    logic [bda_pkg::STATUS_W-1:0]  status;
    logic [bda_pkg::PIN_W-1:0]     pressed_mask;

    modport source (output valid, output status, output pressed_mask, input ready);
    modport sink   (input valid, input status, input pressed_mask, output ready);
endinterface

[hdl/bda_lane.sv]
module bda_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  bda_pkg::lane_step_t step,
    input  bda_pkg::lane_cfg_t  cfg,
    input  logic                clear_repeat,
    output bda_pkg::lane_out_t  result
);
    import bda_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] deb_reg, deb_next;
    logic [CNT_W-1:0] rep_reg, rep_next;
    logic [CNT_W:0]   deb_inc;
    logic [CNT_W-1:0] rep_inc;
    logic [STATUS_W-1:0] status;

    assign deb_inc = {1'b0, deb_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign rep_inc = rep_reg + {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        phase_next = phase_reg;
        deb_next   = deb_reg;
        rep_next   = rep_reg;
        status     = ST_NONE;
        if (enable)
        begin
            priority if (step.flush)
            begin
                phase_next = PH_PROCESSED;
            end
            else if (step.query_hit)
            begin
                if (phase_reg == PH_PRESSED)
                begin
                    phase_next = PH_STILL;
                    status     = ST_PRESSED;
                end
                else if (phase_reg == PH_STILL)
                begin
                    status = ST_STILL;
                end
            end
            else if (step.tick && phase_reg != PH_PRESSED)
            begin
                if (step.pin_high)
                begin
                    phase_next = PH_COUNT;
                    deb_next   = '0;
                    rep_next   = '0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_COUNT:
                        begin
                            if (deb_inc >= {1'b0, cfg.debounce_ticks})
                            begin
                                phase_next = PH_PRESSED;
                                deb_next   = '0;
                            end
                            else
                            begin
                                deb_next = deb_inc[CNT_W-1:0];
                            end
                        end
                        PH_PROCESSED, PH_STILL:
                        begin
                            if (step.rep_en)
                            begin
                                if (rep_inc == cfg.repeat_first)
                                begin
                                    rep_next   = cfg.repeat_reload;
                                    phase_next = PH_PRESSED;
                                end
                                else
                                begin
                                    rep_next = rep_inc;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
        if (clear_repeat)
        begin
            rep_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COUNT;
            deb_reg   <= '0;
            rep_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            deb_reg   <= deb_next;
            rep_reg   <= rep_next;
        end
    end

    assign result.pressed = (phase_next == PH_PRESSED);
    assign result.status  = status;

endmodule

[hdl/bda_merge.sv]
module bda_merge #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  bda_pkg::lane_out_t lane_out [NUM_BUTTONS],
    output logic               can_take,
    bda_out_if.source          out_ch
);
    import bda_pkg::*;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PIN_W-1:0]    mask_reg, mask_next;

    // Only the queried lane reports a nonzero status, so an OR picks it.
    always_comb
    begin
        status_next = ST_NONE;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            status_next = status_next | lane_out[i].status;
        end
    end

    always_comb
    begin
        mask_next = '0;
        for (int i = 0; i < PIN_W; i++)
        begin
            if (i < NUM_BUTTONS)
            begin
                mask_next[i] = lane_out[i].pressed;
            end
        end
    end

    assign can_take = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            mask_reg   <= mask_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.pressed_mask = mask_reg;

endmodule

[hdl/button_debounce_autorepeat.sv]
// A result is valid on the output register in the cycle after its transfer.
// Throughput: one item per cycle unless the output stalls; buttons update in
// parallel, and the output register takes a new result as its old one leaves.
// Reset (rst_n low, asynchronous): every button counting with zero counts, output
// empty, registers at mask 0, debounce 5, repeat first 50, repeat reload 37.
module button_debounce_autorepeat #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bda_in_if.sink                          in_ch,
    bda_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [bda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bda_pkg::*;

    // Configuration registers.
    logic [PIN_W-1:0] repeat_mask_reg;
    lane_cfg_t        cfg_reg;
    logic             clear_repeat;

    // Any write to the enable mask also wipes every repeat counter.
    assign clear_repeat = cfg_we && (cfg_index == REG_REPEAT_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_mask_reg       <= REPEAT_MASK_RST;
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            cfg_reg.repeat_first   <= REPEAT_FIRST_RST;
            cfg_reg.repeat_reload  <= REPEAT_RELOAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REPEAT_MASK:   repeat_mask_reg        <= cfg_data[PIN_W-1:0];
                REG_DEBOUNCE:      cfg_reg.debounce_ticks <= cfg_data;
                REG_REPEAT_FIRST:  cfg_reg.repeat_first   <= cfg_data;
                REG_REPEAT_RELOAD: cfg_reg.repeat_reload  <= cfg_data;
                default:           repeat_mask_reg        <= repeat_mask_reg;
            endcase
        end
    end

    // Input handshake: take a transfer whenever the output register can move.
    logic accept;
    logic can_take;
    logic is_tick, is_query, is_flush;

    assign in_ch.ready = can_take;
    assign accept      = in_ch.valid && can_take;

    assign is_tick  = (in_ch.command == CMD_TICK);
    assign is_query = (in_ch.command == CMD_QUERY);
    assign is_flush = (in_ch.command == CMD_FLUSH);

    // One lane per button. Buttons without a pin bit see a pushed pin, and
    // only buttons covered by the mask field can auto-repeat.
    lane_out_t lane_out [NUM_BUTTONS];

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        lane_step_t step;
        logic       pin_high;
        logic       rep_en;
        logic       hit;

        if (i < PIN_W)
        begin : g_pin
            assign pin_high = in_ch.pin_levels[i];
            assign rep_en   = repeat_mask_reg[i];
        end
        else
        begin : g_nopin
            assign pin_high = 1'b0;
            assign rep_en   = 1'b0;
        end

        if (i < (1 << IDX_W))
        begin : g_idx
            assign hit = (in_ch.button_index == IDX_W'(i));
        end
        else
        begin : g_noidx
            assign hit = 1'b0;
        end

        assign step.tick      = is_tick;
        assign step.query_hit = is_query && hit;
        assign step.flush     = is_flush;
        assign step.pin_high  = pin_high;
        assign step.rep_en    = rep_en;

        bda_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .enable       (accept),
            .step         (step),
            .cfg          (cfg_reg),
            .clear_repeat (clear_repeat),
            .result       (lane_out[i])
        );
    end

    // Gather status and the fresh-press mask into the output register.
    bda_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .lane_out (lane_out),
        .can_take (can_take),
        .out_ch   (out_ch)
    );

    // Checks.
`include "button_debounce_autorepeat_assert.svh"

    `BDA_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_ch.valid)
    `BDA_ASSERT_NEXT(a_nonquery_status_zero, clk, rst_n, accept && !is_query,
                     out_ch.status == ST_NONE)
    `BDA_ASSERT_NEXT(a_flush_clears_mask, clk, rst_n, accept && is_flush,
                     out_ch.pressed_mask == '0)
    `BDA_ASSERT_IMP(a_status_code_valid, clk, rst_n, out_ch.valid,
                    out_ch.status <= ST_STILL)

endmodule

[test/button_debounce_autorepeat_checker.sv]
module button_debounce_autorepeat_checker
    import bda_pkg::*;
#(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bda_in_if                     in_ch,
    bda_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 30;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PIN_W-1:0]    pressed_mask;
    } key_report_t;

    phase_t           key_phase    [NUM_BUTTONS];
    logic [CNT_W-1:0] low_ticks    [NUM_BUTTONS];
    logic [CNT_W-1:0] repeat_ticks [NUM_BUTTONS];

    logic [PIN_W-1:0] repeat_mask;
    logic [CNT_W-1:0] debounce_limit;
    logic [CNT_W-1:0] repeat_fire;
    logic [CNT_W-1:0] repeat_restart;

    key_report_t expected_reports [$];

    task automatic reset_keys();
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            key_phase[i]    = PH_COUNT;
            low_ticks[i]    = '0;
            repeat_ticks[i] = '0;
        end
        repeat_mask    = REPEAT_MASK_RST;
        debounce_limit = DEBOUNCE_TICKS_RST;
        repeat_fire    = REPEAT_FIRST_RST;
        repeat_restart = REPEAT_RELOAD_RST;
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (cfg_reg_t'(idx))
            REG_REPEAT_MASK:
            begin
                repeat_mask = data[PIN_W-1:0];
                for (int i = 0; i < NUM_BUTTONS; i++)
                    repeat_ticks[i] = '0;
            end
            REG_DEBOUNCE:      debounce_limit = data;
            REG_REPEAT_FIRST:  repeat_fire    = data;
            REG_REPEAT_RELOAD: repeat_restart = data;
            default: ;
        endcase
    endtask

    // One sampling tick across all buttons; a latched press ignores its pin.
    task automatic sample_pins(input logic [PIN_W-1:0] pins);
        logic             pin_high;
        logic             rep_on;
        logic [CNT_W:0]   next_low;
        logic [CNT_W-1:0] next_rep;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            pin_high = (i < PIN_W) ? pins[i] : 1'b0;
            rep_on   = (i < PIN_W) ? repeat_mask[i] : 1'b0;
            if (key_phase[i] == PH_PRESSED)
                continue;
            if (pin_high) begin
                key_phase[i]    = PH_COUNT;
                low_ticks[i]    = '0;
                repeat_ticks[i] = '0;
            end
            else if (key_phase[i] == PH_COUNT) begin
                next_low = {1'b0, low_ticks[i]} + (CNT_W+1)'(1);
                if (next_low >= {1'b0, debounce_limit}) begin
                    key_phase[i] = PH_PRESSED;
                    low_ticks[i] = '0;
                end
                else begin
                    low_ticks[i] = next_low[CNT_W-1:0];
                end
            end
            else if (rep_on) begin
                next_rep = repeat_ticks[i] + CNT_W'(1);
                if (next_rep == repeat_fire) begin
                    repeat_ticks[i] = repeat_restart;
                    key_phase[i]    = PH_PRESSED;
                end
                else begin
                    repeat_ticks[i] = next_rep;
                end
            end
        end
    endtask

    task automatic predict_report(input  logic [CMD_W-1:0] cmd,
                                  input  logic [PIN_W-1:0] pins,
                                  input  logic [IDX_W-1:0] idx,
                                  output key_report_t      rep);
        rep = '0;
        case (cmd_t'(cmd))
            CMD_TICK: sample_pins(pins);
            CMD_QUERY:
            begin
                if (idx < NUM_BUTTONS) begin
                    if (key_phase[idx] == PH_PRESSED) begin
                        key_phase[idx] = PH_STILL;
                        rep.status     = ST_PRESSED;
                    end
                    else if (key_phase[idx] == PH_STILL) begin
                        rep.status = ST_STILL;
                    end
                end
            end
            CMD_FLUSH:
            begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                    key_phase[i] = PH_PROCESSED;
            end
            default: ;
        endcase
        for (int i = 0; i < NUM_BUTTONS && i < PIN_W; i++)
            if (key_phase[i] == PH_PRESSED)
                rep.pressed_mask[i] = 1'b1;
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        if (mismatches < REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h",
                     $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        key_report_t want;
        key_report_t got;
        if (!rst_n) begin
            reset_keys();
            expected_reports.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            // a result always belongs to an earlier item, so retire before predicting
            if (out_ch.valid && out_ch.ready) begin
                got.status       = out_ch.status;
                got.pressed_mask = out_ch.pressed_mask;
                if (expected_reports.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t ns: result with nothing expected, status %0d mask %b",
                                 $time, got.status, got.pressed_mask);
                    mismatches++;
                end
                else begin
                    want = expected_reports.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", int'(want.status), int'(got.status));
                    if (got.pressed_mask !== want.pressed_mask)
                        report_mismatch("pressed_mask", int'(want.pressed_mask),
                                        int'(got.pressed_mask));
                end
            end
            if (cfg_we)
                write_setting(cfg_index, cfg_data);
            if (in_ch.valid && in_ch.ready) begin
                predict_report(in_ch.command, in_ch.pin_levels, in_ch.button_index, want);
                expected_reports.push_back(want);
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

[test/button_debounce_autorepeat_tb.sv]
module button_debounce_autorepeat_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bda_pkg::*;

    localparam int NUM_BUTTONS = 6;
    localparam int SETUP_COUNT = 8;

    // One register setting plus the shape of the random traffic run under it.
    // drift_pct is the chance per tick that the held pin pattern moves; zero
    // means every pin stays pushed so long counts can run out.
    typedef struct {
        logic [PIN_W-1:0]      repeat_mask;
        logic [CFG_DATA_W-1:0] debounce;
        logic [CFG_DATA_W-1:0] first_fire;
        logic [CFG_DATA_W-1:0] reload;
        int                    item_count;
        int                    drift_pct;
    } key_setup_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int               idle_pct;
    int               stall_pct;
    int               mismatches;
    int               outstanding;
    logic [PIN_W-1:0] held_pins;
    key_setup_t       plan [SETUP_COUNT];

    bda_in_if  in_ch ();
    bda_out_if out_ch ();

    button_debounce_autorepeat #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker predicts every transfer and compares; this module only
    // drives traffic and reads back the failure count.
    button_debounce_autorepeat_checker #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Receiver side: stall the result channel at random, redrawn every cycle.
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Write one register; the write lands on the next rising edge.
    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one item and hold it until the transfer happens. An idle gap, when
    // drawn, drops valid first so the block sees bubbles between items.
    task automatic send_item(input cmd_t cmd, input logic [PIN_W-1:0] pins,
                             input logic [IDX_W-1:0] idx);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(3, 0);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.pin_levels   <= pins;
        in_ch.button_index <= idx;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted result has come back,
    // then let the pipeline settle before anything else happens.
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apply_setup(input key_setup_t s);
        write_reg(REG_REPEAT_MASK, s.repeat_mask);
        write_reg(REG_DEBOUNCE, s.debounce);
        write_reg(REG_REPEAT_FIRST, s.first_fire);
        write_reg(REG_REPEAT_RELOAD, s.reload);
    endtask

    // Random traffic built around a held pin pattern: buttons stay pushed or
    // released for stretches, so debounce and repeat counts really run out.
    // Bounce noise flips a few pins for a single tick. With no drift, queries and
    // flushes are left out too, since a flush would stop the debounce count.
    task automatic run_random(input int count, input int drift_pct);
        int               roll;
        logic [PIN_W-1:0] pins;
        logic [IDX_W-1:0] idx;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            pins = PIN_W'($urandom_range((1 << PIN_W) - 1, 0));
            idx  = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(7, 6))
                                             : IDX_W'($urandom_range(5, 0));
            if (roll < 74 || (drift_pct == 0 && roll < 96)) begin
                if (drift_pct != 0 && $urandom_range(99) < drift_pct) begin
                    if ($urandom_range(3) == 0)
                        held_pins = PIN_W'($urandom_range((1 << PIN_W) - 1, 0));
                    else
                        held_pins[$urandom_range(PIN_W - 1, 0)] ^= 1'b1;
                end
                if (drift_pct != 0 && $urandom_range(99) < 10)
                    pins = held_pins ^ pins;
                else
                    pins = held_pins;
                send_item(CMD_TICK, pins, idx);
            end
            else if (roll < 92)
                send_item(CMD_QUERY, pins, idx);
            else if (roll < 96)
                send_item(CMD_FLUSH, pins, idx);
            else
                send_item(CMD_NOP, pins, idx);
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_REPEAT_MASK;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_NOP;
        in_ch.pin_levels   = '1;
        in_ch.button_index = '0;
        out_ch.ready       = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        held_pins          = '1;

        // Settings swept after the directed part: mask, debounce, repeat
        // first, repeat reload, items, pin drift. Values near both ends of every
        // register show up, including a zero debounce that latches on the first tick.
        plan[0] = '{6'h3F, 8'd1,   8'd2,   8'd0,   80,  8};
        plan[1] = '{6'h2A, 8'd3,   8'd5,   8'd1,   80,  5};
        plan[2] = '{6'h15, 8'd0,   8'd4,   8'd3,   80,  8};
        plan[3] = '{6'h3F, 8'd250, 8'd255, 8'd254, 300, 0};
        plan[4] = '{6'h3F, 8'd2,   8'd255, 8'd254, 300, 0};
        plan[5] = '{6'h2D, 8'd4,   8'd9,   8'd2,   80,  4};
        plan[6] = '{6'h00, 8'd5,   8'd50,  8'd37,  80,  6};
        plan[7] = '{6'h3F, 8'd2,   8'd6,   8'd5,   80,  3};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: release all, hold all low
        // until every button latches, then walk the query answers, the
        // out-of-range indexes, the unused command and a flush that also
        // catches counting buttons.
        send_item(CMD_TICK, 6'h3F, 3'd0);
        repeat (5) send_item(CMD_TICK, 6'h00, 3'd0);
        send_item(CMD_QUERY, 6'h00, 3'd0);
        send_item(CMD_QUERY, 6'h3F, 3'd0);
        send_item(CMD_QUERY, 6'h00, 3'd5);
        send_item(CMD_QUERY, 6'h00, 3'd6);
        send_item(CMD_QUERY, 6'h00, 3'd7);
        send_item(CMD_NOP, 6'h3F, 3'd7);
        send_item(CMD_TICK, 6'h15, 3'd0);
        send_item(CMD_FLUSH, 6'h00, 3'd0);
        send_item(CMD_QUERY, 6'h00, 3'd1);
        send_item(CMD_TICK, 6'h2A, 3'd0);
        send_item(CMD_TICK, 6'h00, 3'd0);
        send_item(CMD_QUERY, 6'h00, 3'd4);
        send_item(CMD_QUERY, 6'h00, 3'd2);
        send_item(CMD_QUERY, 6'h00, 3'd3);
        drain_results();

        // Random part: one setting at a time, with the idle pattern rotating
        // through none, sender gaps, receiver stalls and both.
        for (int k = 0; k < SETUP_COUNT; k++) begin
            apply_setup(plan[k]);
            case (k % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 52; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            if (plan[k].drift_pct == 0)
                held_pins = '0;
            else
                held_pins = PIN_W'($urandom_range((1 << PIN_W) - 1, 0));
            run_random(plan[k].item_count, plan[k].drift_pct);
            drain_results();
        end

        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("button_debounce_autorepeat verification clean");
        else
            $display("button_debounce_autorepeat verification failed");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("button_debounce_autorepeat verification failed");
        $finish;
    end

endmodule
